FILE: rtl/srdc_pkg.sv
// Shared types and constants for the sensor report dedup cache.
// No dependencies.
package srdc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [31:0] INTERVAL_RESET = 32'd3000;
    localparam int SLOT_W = 4;

    typedef enum logic [2:0] {
        OUT_SUPPRESSED = 3'd0,
        OUT_NEW        = 3'd1,
        OUT_CHANGED    = 3'd2,
        OUT_EXPIRED    = 3'd3,
        OUT_REPLACED   = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [47:0]        address;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [7:0]         battery;
        logic [31:0]        now_time;
    } query_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              done;
        logic              emit;
        outcome_t          outcome;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       oldest_time;
    } token_t;

endpackage

FILE: rtl/srdc_cell.sv
// One table entry of the dedup cache with its slice of the scan.
// Depends on srdc_pkg.
module srdc_cell import srdc_pkg::*; #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  query_t           query,
    input  logic [31:0]      interval,
    input  token_t           tok_in,
    input  logic [IDX_W-1:0] oldest_in,
    output token_t           tok_out,
    output logic [IDX_W-1:0] oldest_out,
    input  logic             rep_wr,
    input  logic [IDX_W-1:0] rep_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               valid_reg;
    logic [47:0]        addr_reg;
    logic [15:0]        temp_reg;
    logic [15:0]        hum_reg;
    logic [7:0]         batt_reg;
    logic [31:0]        time_reg;

    token_t             tok_reg, tok_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic               self_wr;
    logic               changed;
    logic               expired;
    logic [31:0]        age;

    always_comb begin
        age      = query.now_time - time_reg;
        expired  = age >= interval;
        changed  = (temp_reg != query.temperature) || (hum_reg != query.humidity) ||
                   (batt_reg != query.battery);
        tok_next    = tok_in;
        oldest_next = oldest_in;
        self_wr     = 1'b0;
        if (tok_in.active && !tok_in.done) begin
            if (!valid_reg) begin
                self_wr          = 1'b1;
                tok_next.done    = 1'b1;
                tok_next.emit    = 1'b1;
                tok_next.outcome = OUT_NEW;
                tok_next.slot    = SLOT_W'(CELL_IDX);
            end else begin
                if (time_reg < tok_in.oldest_time) begin
                    tok_next.oldest_time = time_reg;
                    oldest_next          = MY_IDX;
                end
                if (addr_reg == query.address) begin
                    tok_next.done = 1'b1;
                    tok_next.slot = SLOT_W'(CELL_IDX);
                    if (changed || expired) begin
                        self_wr          = 1'b1;
                        tok_next.emit    = 1'b1;
                        tok_next.outcome = changed ? OUT_CHANGED : OUT_EXPIRED;
                    end else begin
                        tok_next.emit    = 1'b0;
                        tok_next.outcome = OUT_SUPPRESSED;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg    <= tok_next;
            oldest_reg <= oldest_next;
            if (self_wr || (rep_wr && rep_idx == MY_IDX)) begin
                valid_reg <= 1'b1;
                addr_reg  <= query.address;
                temp_reg  <= query.temperature;
                hum_reg   <= query.humidity;
                batt_reg  <= query.battery;
                time_reg  <= query.now_time;
            end
        end
    end

    assign tok_out    = tok_reg;
    assign oldest_out = oldest_reg;

endmodule

FILE: rtl/sensor_report_dedup_cache_core.sv
// Sensor report dedup cache: input and result channels, config register,
// scan control and the row of srdc_cell entries. Depends on srdc_pkg, srdc_cell.
// One item at a time: the start token walks the row of cell registers, and the
// scan result waits in the pending register until the result register is free.
// The result register lets the next item in while a result waits.
// Reset: entry valid bits cleared, interval back to 3000, no item in flight.
module sensor_report_dedup_cache_core import srdc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [47:0]         s_sensor_address,
    input  logic signed [15:0]  s_temperature,
    input  logic [15:0]         s_humidity,
    input  logic [7:0]          s_battery_level,
    input  logic [31:0]         s_now_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_emit,
    output logic [2:0]          m_outcome,
    output logic [SLOT_W-1:0]   m_slot,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_republish_interval
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t             state_reg;
    logic [31:0]        interval_reg;
    query_t             query_reg;
    token_t             start_reg;
    token_t             pend_reg;
    logic [IDX_W-1:0]   pend_oldest_reg;
    logic               m_valid_reg;
    logic               m_emit_reg;
    outcome_t           m_outcome_reg;
    logic [SLOT_W-1:0]  m_slot_reg;

    token_t             tok [ENTRIES+1];
    logic [IDX_W-1:0]   oldest [ENTRIES+1];
    logic               out_free;
    logic               rep_wr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign rep_wr    = (state_reg == ST_DONE) && out_free && !pend_reg.done;

    assign tok[0]    = start_reg;
    assign oldest[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        srdc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .query      (query_reg),
            .interval   (interval_reg),
            .tok_in     (tok[i]),
            .oldest_in  (oldest[i]),
            .tok_out    (tok[i+1]),
            .oldest_out (oldest[i+1]),
            .rep_wr     (rep_wr),
            .rep_idx    (pend_oldest_reg)
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            interval_reg     <= INTERVAL_RESET;
            start_reg.active <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                interval_reg <= cfg_republish_interval;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        query_reg.address     <= s_sensor_address;
                        query_reg.temperature <= s_temperature;
                        query_reg.humidity    <= s_humidity;
                        query_reg.battery     <= s_battery_level;
                        query_reg.now_time    <= s_now_time;
                        start_reg.active      <= 1'b1;
                        start_reg.done        <= 1'b0;
                        start_reg.emit        <= 1'b0;
                        start_reg.outcome     <= OUT_SUPPRESSED;
                        start_reg.slot        <= '0;
                        start_reg.oldest_time <= '1;
                        state_reg             <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    start_reg.active <= 1'b0;
                    if (tok[ENTRIES].active) begin
                        pend_reg        <= tok[ENTRIES];
                        pend_oldest_reg <= oldest[ENTRIES];
                        state_reg       <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (pend_reg.done) begin
                            m_emit_reg    <= pend_reg.emit;
                            m_outcome_reg <= pend_reg.outcome;
                            m_slot_reg    <= pend_reg.slot;
                        end else begin
                            m_emit_reg    <= 1'b1;
                            m_outcome_reg <= OUT_REPLACED;
                            m_slot_reg    <= SLOT_W'(pend_oldest_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_emit    = m_emit_reg;
    assign m_outcome = m_outcome_reg;
    assign m_slot    = m_slot_reg;

endmodule
